>>> hdl/fcct_pkg.sv
// ----------------------------------------------------------------------------
// fcct_pkg
// Types, codes and helpers shared by the cluster chain table and its channels.
// ----------------------------------------------------------------------------
package fcct_pkg;

  localparam int MaxClusters = 4096;
  localparam int TableDepth  = MaxClusters + 2;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int EntryW      = 28;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 13;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [EntryW-1:0]   entry_t;
  typedef logic [1:0]          kind_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_FOLLOW = 2'd1,
    ACT_ALLOC  = 2'd2,
    ACT_FREE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BROKEN   = 2'd2
  } status_t;

  localparam kind_t FAT12 = 2'd0;
  localparam kind_t FAT16 = 2'd1;

  localparam cfg_idx_t CFG_FAT_KIND      = 1'b0;
  localparam cfg_idx_t CFG_CLUSTER_COUNT = 1'b1;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

  function automatic entry_t entry_mask(kind_t kind);
    entry_t m;
    unique case (kind)
      FAT12:   m = 28'h0000FFF;
      FAT16:   m = 28'h000FFFF;
      default: m = 28'hFFFFFFF;
    endcase
    return m;
  endfunction

  function automatic logic is_end(entry_t v, entry_t m);
    return (v >= m - 28'd7) && (v <= m);
  endfunction

endpackage

>>> hdl/fcct_if.sv
// ----------------------------------------------------------------------------
// fcct channels
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface fcct_req_if;
  import fcct_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  idx_t    cluster;
  idx_t    link_from;
  entry_t  load_value;

  modport source (output valid, action, cluster, link_from, load_value, input ready);
  modport sink   (input valid, action, cluster, link_from, load_value, output ready);
endinterface

interface fcct_rsp_if;
  import fcct_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  entry_t  cluster_out;

  modport source (output valid, status, cluster_out, input ready);
  modport sink   (input valid, status, cluster_out, output ready);
endinterface

>>> hdl/fcct_link_ram.sv
// ----------------------------------------------------------------------------
// fcct_link_ram
// Link table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcct_link_ram (
  input  logic              clk,
  input  fcct_pkg::ram_wr_t wr,
  input  fcct_pkg::ram_rd_t rd,
  output fcct_pkg::entry_t  rdata
);
  import fcct_pkg::*;

  entry_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

>>> hdl/fat_cluster_chain_table.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_table
// File allocation table of cluster links with load, follow, allocate and free.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one response. All table
// accesses go through a single link memory with a registered read port.
// Allocate scans from cluster 2 up to the clipped cluster_count + 1 for the
// first free entry, marks it as end of chain and links link_from to it when
// that is set; free clears each cluster on the chain. A new request is taken
// while a finished response still waits for transfer. The table is not
// cleared at reset; entries must be loaded before they are read.
// ----------------------------------------------------------------------------
module fat_cluster_chain_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  fcct_pkg::cfg_idx_t  cfg_index,
  input  fcct_pkg::cfg_data_t cfg_data,
  fcct_req_if.sink            req,
  fcct_rsp_if.source          rsp
);
  import fcct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLLOW,
    S_SCAN,
    S_MARK,
    S_LINK,
    S_WALK_CHK,
    S_WALK_DATA,
    S_RESP
  } state_t;

  state_t    state;
  kind_t     fat_kind;
  cfg_data_t cluster_count;
  entry_t    cur;
  idx_t      from;
  idx_t      scan_addr;
  logic      pend;
  idx_t      pend_addr;
  status_t   res_status;
  entry_t    res_cluster;
  logic      rsp_valid;
  status_t   rsp_status;
  entry_t    rsp_cluster;

  ram_wr_t   wr;
  ram_rd_t   rd;
  entry_t    rdata;
  entry_t    mask;
  idx_t      hi;
  logic      hit;
  logic      cur_end;
  logic      cur_in;

  fcct_link_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.cluster_out = rsp_cluster;

  assign mask    = entry_mask(fat_kind);
  assign hi      = ((cluster_count > idx_t'(MaxClusters)) ? idx_t'(MaxClusters)
                    : idx_t'(cluster_count)) + idx_t'(1);
  assign hit     = pend && ((rdata & mask) == '0);
  assign cur_end = is_end(cur, mask);
  assign cur_in  = (cur >= entry_t'(2)) && (cur <= entry_t'(hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_kind      <= 2'd2;
      cluster_count <= cfg_data_t'(MaxClusters);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAT_KIND:      fat_kind <= cfg_data[1:0];
        CFG_CLUSTER_COUNT: cluster_count <= cfg_data;
      endcase
    end
  end

  always_comb begin
    wr = '0;
    rd = '0;
    unique case (state)
      S_IDLE: begin
        if (req.valid && (req.cluster < idx_t'(TableDepth))) begin
          if (req.action == ACT_LOAD) begin
            wr.en   = 1'b1;
            wr.addr = req.cluster;
            wr.data = req.load_value & mask;
          end else if (req.action == ACT_FOLLOW) begin
            rd.en   = 1'b1;
            rd.addr = req.cluster;
          end
        end
      end
      S_SCAN: begin
        if (!hit && (scan_addr <= hi)) begin
          rd.en   = 1'b1;
          rd.addr = scan_addr;
        end
      end
      S_MARK: begin
        wr.en   = 1'b1;
        wr.addr = pend_addr;
        wr.data = mask;
      end
      S_LINK: begin
        wr.en   = 1'b1;
        wr.addr = from;
        wr.data = entry_t'(pend_addr) & mask;
      end
      S_WALK_CHK: begin
        if (!cur_end && cur_in) begin
          rd.en   = 1'b1;
          rd.addr = cur[IdxW-1:0];
        end
      end
      S_WALK_DATA: begin
        wr.en   = 1'b1;
        wr.addr = cur[IdxW-1:0];
        wr.data = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_status  <= ST_OK;
            res_cluster <= '0;
            cur         <= entry_t'(req.cluster);
            from        <= req.link_from;
            scan_addr   <= idx_t'(2);
            pend        <= 1'b0;
            unique case (req.action)
              ACT_LOAD:   state <= S_RESP;
              ACT_FOLLOW: begin
                if (req.cluster < idx_t'(TableDepth)) begin
                  state <= S_FOLLOW;
                end else begin
                  res_status <= ST_BROKEN;
                  state      <= S_RESP;
                end
              end
              ACT_ALLOC:  state <= S_SCAN;
              ACT_FREE:   state <= S_WALK_CHK;
            endcase
          end
        end
        S_FOLLOW: begin
          res_cluster <= rdata & mask;
          state       <= S_RESP;
        end
        S_SCAN: begin
          pend <= 1'b0;
          if (hit) begin
            state <= S_MARK;
          end else if (scan_addr > hi) begin
            res_status <= ST_NO_SPACE;
            state      <= S_RESP;
          end else begin
            pend      <= 1'b1;
            pend_addr <= scan_addr;
            scan_addr <= scan_addr + idx_t'(1);
          end
        end
        S_MARK: begin
          res_cluster <= entry_t'(pend_addr);
          if ((from != '0) && (from < idx_t'(TableDepth))) begin
            state <= S_LINK;
          end else begin
            state <= S_RESP;
          end
        end
        S_LINK: begin
          state <= S_RESP;
        end
        S_WALK_CHK: begin
          if (cur_end) begin
            state <= S_RESP;
          end else if (!cur_in) begin
            res_status <= ST_BROKEN;
            state      <= S_RESP;
          end else begin
            state <= S_WALK_DATA;
          end
        end
        S_WALK_DATA: begin
          cur   <= rdata & mask;
          state <= S_WALK_CHK;
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= res_status;
            rsp_cluster <= res_cluster;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
